### rtl/core/tscc_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and helpers for the touch stream consistency checker.
package tscc_pkg;

  localparam int unsigned MAX_POINTER_IDS = 32;
  localparam int unsigned CFG_AW = 3;
  localparam int unsigned NUM_VIOL = 13;

  localparam logic [31:0] PCM_RESET = 32'd2;

  localparam logic [0:0] REG_POINTER_CLASS_MASK = 1'b0;

  localparam int unsigned V_MIXED      = 0;
  localparam int unsigned V_DOWN_PTRS  = 1;
  localparam int unsigned V_HISTORY    = 2;
  localparam int unsigned V_COUNT_ONE  = 3;
  localparam int unsigned V_MOVE_CNT   = 4;
  localparam int unsigned V_OUTSIDE    = 5;
  localparam int unsigned V_PD_NONE    = 6;
  localparam int unsigned V_PD_INDEX   = 7;
  localparam int unsigned V_PD_ALREADY = 8;
  localparam int unsigned V_PU_INDEX   = 9;
  localparam int unsigned V_PU_NOTDOWN = 10;
  localparam int unsigned V_INVALID    = 11;
  localparam int unsigned V_NOT_PTR    = 12;

  typedef enum logic [3:0] {
    MODE_DOWN         = 4'd0,
    MODE_UP           = 4'd1,
    MODE_MOVE         = 4'd2,
    MODE_CANCEL       = 4'd3,
    MODE_OUTSIDE      = 4'd4,
    MODE_POINTER_DOWN = 4'd5,
    MODE_POINTER_UP   = 4'd6,
    MODE_OTHER        = 4'd7,
    MODE_UNHANDLED    = 4'd8
  } mode_e;

  typedef struct packed {
    logic [3:0]  mode;
    logic [31:0] seq_number;
    logic [1:0]  nesting_level;
    logic [15:0] device_id;
    logic [31:0] source_bits;
    logic [5:0]  pointer_count;
    logic [4:0]  action_index;
    logic [4:0]  pointer_id;
    logic [7:0]  history_size;
  } evt_word_t;

  typedef struct packed {
    logic      valid;
    evt_word_t word;
  } stage_t;

  function automatic logic [31:0] id_bit(input logic [4:0] id);
    logic [31:0] b;
    b = '0;
    if (32'(id) < MAX_POINTER_IDS) begin
      b = 32'd1 << id;
    end
    return b;
  endfunction

  function automatic logic [5:0] ones_count(input logic [31:0] v);
    logic [5:0] n;
    n = '0;
    for (int i = 0; i < 32; i++) begin
      n = n + 6'(v[i]);
    end
    return n;
  endfunction

endpackage

### rtl/core/tscc_if.sv
`timescale 1ns / 1ps
// Event and result channel interfaces with valid/ready handshake.
interface tscc_evt_if;
  logic        valid;
  logic        ready;
  logic [3:0]  mode;
  logic [31:0] seq_number;
  logic [1:0]  nesting_level;
  logic [15:0] device_id;
  logic [31:0] source_bits;
  logic [5:0]  pointer_count;
  logic [4:0]  action_index;
  logic [4:0]  pointer_id;
  logic [7:0]  history_size;

  modport source (
    output valid, mode, seq_number, nesting_level, device_id, source_bits,
           pointer_count, action_index, pointer_id, history_size,
    input  ready
  );
  modport sink (
    input  valid, mode, seq_number, nesting_level, device_id, source_bits,
           pointer_count, action_index, pointer_id, history_size,
    output ready
  );
endinterface

interface tscc_res_if;
  logic        valid;
  logic        ready;
  logic        checked;
  logic        taint_event;
  logic [12:0] violations;
  logic [31:0] pointers_down;

  modport source (
    output valid, checked, taint_event, violations, pointers_down,
    input  ready
  );
  modport sink (
    input  valid, checked, taint_event, violations, pointers_down,
    output ready
  );
endinterface

### rtl/core/tscc_apb.sv
`timescale 1ns / 1ps
// APB configuration register holding the pointer class mask.
module tscc_apb import tscc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output logic [31:0]       pcm_o
);

  logic [31:0] pcm_q;
  logic [31:0] pcm_d;
  logic        hit;

  assign pready = 1'b1;
  assign hit    = (paddr[CFG_AW-1:2] == REG_POINTER_CLASS_MASK);

  always_comb begin
    pcm_d = pcm_q;
    if (psel && penable && pwrite && pready && hit) begin
      pcm_d = pwdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pcm_q <= PCM_RESET;
    end else begin
      pcm_q <= pcm_d;
    end
  end

  assign prdata = hit ? pcm_q : '0;
  assign pcm_o  = pcm_q;

endmodule

### rtl/core/tscc_ingress.sv
`timescale 1ns / 1ps
// Input register stage for incoming event words.
module tscc_ingress import tscc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  tscc_evt_if.sink   evt_i,
  input  logic       adv_i,
  output stage_t     stg_o
);

  logic      valid_q;
  logic      valid_d;
  evt_word_t word_q;
  logic      load;

  assign evt_i.ready = !valid_q || adv_i;
  assign load        = evt_i.valid && evt_i.ready;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (adv_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      word_q <= '{mode:          evt_i.mode,
                  seq_number:    evt_i.seq_number,
                  nesting_level: evt_i.nesting_level,
                  device_id:     evt_i.device_id,
                  source_bits:   evt_i.source_bits,
                  pointer_count: evt_i.pointer_count,
                  action_index:  evt_i.action_index,
                  pointer_id:    evt_i.pointer_id,
                  history_size:  evt_i.history_size};
    end
  end

  assign stg_o.valid = valid_q;
  assign stg_o.word  = word_q;

endmodule

### rtl/core/tscc_core.sv
`timescale 1ns / 1ps
// Stream state, per-event checks and result register.
module tscc_core import tscc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  stage_t      stg_i,
  input  logic [31:0] pcm_i,
  output logic        adv_o,
  tscc_res_if.source  res_o
);

  logic [31:0] mask_q, mask_d;
  logic        tainted_q, tainted_d;
  logic        unhandled_q, unhandled_d;
  logic        dev_valid_q, dev_valid_d;
  logic [15:0] dev_q, dev_d;
  logic [31:0] src_q, src_d;
  logic        pseq_valid_q, pseq_valid_d;
  logic [31:0] pseq_q, pseq_d;
  logic [1:0]  pnest_q, pnest_d;

  logic        res_valid_q, res_valid_d;
  logic        checked_q, checked_d;
  logic        taint_q, taint_d;
  logic [12:0] viol_q, viol_d;
  logic [31:0] pdown_q;

  logic        fire;
  evt_word_t   w;

  assign w     = stg_i.word;
  assign adv_o = !res_valid_q || res_o.ready;
  assign fire  = stg_i.valid && adv_o;

  always_comb begin
    logic        new_stream;
    logic        taint;
    logic [31:0] b;
    mask_d       = mask_q;
    tainted_d    = tainted_q;
    unhandled_d  = unhandled_q;
    dev_valid_d  = dev_valid_q;
    dev_d        = dev_q;
    src_d        = src_q;
    pseq_valid_d = pseq_valid_q;
    pseq_d       = pseq_q;
    pnest_d      = pnest_q;
    checked_d    = 1'b1;
    viol_d       = '0;
    taint        = 1'b0;
    new_stream   = 1'b0;
    b            = id_bit(w.pointer_id);

    if (w.mode == MODE_UNHANDLED) begin
      if (w.nesting_level == pnest_q) begin
        unhandled_d = 1'b1;
      end else begin
        checked_d = 1'b0;
      end
    end else if (pseq_valid_q && (w.seq_number == pseq_q) &&
                 (w.nesting_level < pnest_q)) begin
      checked_d = 1'b0;
    end else begin
      new_stream = (w.mode == MODE_DOWN) || (w.mode == MODE_CANCEL) ||
                   (w.mode == MODE_OUTSIDE);
      if (w.nesting_level != 2'd0) begin
        pseq_valid_d = 1'b1;
        pseq_d       = w.seq_number;
        pnest_d      = w.nesting_level;
      end else begin
        pseq_valid_d = 1'b0;
        pseq_d       = '0;
        pnest_d      = '0;
      end

      if (new_stream && (tainted_q || unhandled_q)) begin
        tainted_d   = 1'b0;
        unhandled_d = 1'b0;
        mask_d      = '0;
      end
      taint = tainted_d;

      if (!new_stream && dev_valid_q &&
          ((dev_q != w.device_id) || (src_q != w.source_bits))) begin
        viol_d[V_MIXED] = 1'b1;
      end
      dev_valid_d = 1'b1;
      dev_d       = w.device_id;
      src_d       = w.source_bits;

      if ((w.source_bits & pcm_i) == '0) begin
        viol_d[V_NOT_PTR] = 1'b1;
      end else begin
        case (mode_e'(w.mode))
          MODE_DOWN: begin
            viol_d[V_DOWN_PTRS] = (mask_d != '0);
            viol_d[V_HISTORY]   = (w.history_size != '0);
            viol_d[V_COUNT_ONE] = (w.pointer_count != 6'd1);
            mask_d = b;
          end
          MODE_UP: begin
            viol_d[V_HISTORY]   = (w.history_size != '0);
            viol_d[V_COUNT_ONE] = (w.pointer_count != 6'd1);
            mask_d    = '0;
            tainted_d = 1'b0;
          end
          MODE_MOVE: begin
            if (w.pointer_count != ones_count(mask_d)) begin
              viol_d[V_MOVE_CNT] = 1'b1;
              tainted_d = 1'b1;
            end
          end
          MODE_CANCEL: begin
            mask_d    = '0;
            tainted_d = 1'b0;
          end
          MODE_OUTSIDE: begin
            viol_d[V_OUTSIDE]   = (mask_d != '0);
            viol_d[V_HISTORY]   = (w.history_size != '0);
            viol_d[V_COUNT_ONE] = (w.pointer_count != 6'd1);
            tainted_d = 1'b0;
          end
          MODE_POINTER_DOWN: begin
            if (mask_d == '0) begin
              viol_d[V_PD_NONE] = 1'b1;
              tainted_d = 1'b1;
            end
            if (6'(w.action_index) >= w.pointer_count) begin
              viol_d[V_PD_INDEX] = 1'b1;
              tainted_d = 1'b1;
            end else if ((mask_d & b) != '0) begin
              viol_d[V_PD_ALREADY] = 1'b1;
              tainted_d = 1'b1;
            end else begin
              mask_d = mask_d | b;
            end
            viol_d[V_HISTORY] = (w.history_size != '0);
          end
          MODE_POINTER_UP: begin
            if (6'(w.action_index) >= w.pointer_count) begin
              viol_d[V_PU_INDEX] = 1'b1;
              tainted_d = 1'b1;
            end else if ((mask_d & b) == '0) begin
              viol_d[V_PU_NOTDOWN] = 1'b1;
              tainted_d = 1'b1;
            end else begin
              mask_d = mask_d & ~b;
            end
            viol_d[V_HISTORY] = (w.history_size != '0);
          end
          default: begin
            viol_d[V_INVALID] = 1'b1;
          end
        endcase
      end
    end
    taint_d = taint || (viol_d != '0);
  end

  always_comb begin
    res_valid_d = res_valid_q;
    if (fire) begin
      res_valid_d = 1'b1;
    end else if (res_o.ready) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q       <= '0;
      tainted_q    <= 1'b0;
      unhandled_q  <= 1'b0;
      dev_valid_q  <= 1'b0;
      dev_q        <= '0;
      src_q        <= '0;
      pseq_valid_q <= 1'b0;
      pseq_q       <= '0;
      pnest_q      <= '0;
      res_valid_q  <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
      if (fire) begin
        mask_q       <= mask_d;
        tainted_q    <= tainted_d;
        unhandled_q  <= unhandled_d;
        dev_valid_q  <= dev_valid_d;
        dev_q        <= dev_d;
        src_q        <= src_d;
        pseq_valid_q <= pseq_valid_d;
        pseq_q       <= pseq_d;
        pnest_q      <= pnest_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      checked_q <= checked_d;
      taint_q   <= taint_d;
      viol_q    <= viol_d;
      pdown_q   <= mask_d;
    end
  end

  assign res_o.valid         = res_valid_q;
  assign res_o.checked       = checked_q;
  assign res_o.taint_event   = taint_q;
  assign res_o.violations    = viol_q;
  assign res_o.pointers_down = pdown_q;

endmodule

### rtl/core/touch_stream_consistency_checker_top.sv
`timescale 1ns / 1ps
// Top level of the touch stream consistency checker.
//
//   port     dir   kind         carries
//   evt_i    in    valid/ready  one touch event or unhandled notice per word
//   res_o    out   valid/ready  checked, taint_event, violations, pointers_down
//   APB      in    psel/penable pointer_class_mask at byte address 0
//
// Result path: one input register, then the check logic into the result register
// and stream state. Throughput is one word per cycle while the result side is
// ready; stream state updates as each result loads.
// Reset clears stream state and both stage valids, mask resets to 2.
// A stalled result holds the result register and, behind it, the input register.
module touch_stream_consistency_checker_top import tscc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  tscc_evt_if.sink          evt_i,
  tscc_res_if.source        res_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [31:0] pcm;
  logic        adv;
  stage_t      stg;

  tscc_apb u_apb (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .pcm_o   (pcm)
  );

  tscc_ingress u_ingress (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .evt_i  (evt_i),
    .adv_i  (adv),
    .stg_o  (stg)
  );

  tscc_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stg_i  (stg),
    .pcm_i  (pcm),
    .adv_o  (adv),
    .res_o  (res_o)
  );

  a_fire_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stg.valid && adv) |=> res_o.valid)
    else $error("advanced word produced no result");

  a_skip_is_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && !res_o.checked) |-> (res_o.violations == '0 && !res_o.taint_event))
    else $error("unchecked word carries violations or taint");

  a_viol_taints: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.violations != '0) |-> res_o.taint_event)
    else $error("violation without taint");

  a_stall_holds_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stg.valid && !adv) |=> (stg.valid && $stable(stg.word)))
    else $error("input register lost word under stall");

endmodule

### tb/sv/touch_stream_consistency_checker_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the touch stream consistency checker: gestures in, predicted results compared.
module touch_stream_consistency_checker_top_tb;
  import tscc_pkg::*;

  localparam logic [3:0] MODE_UNDEF_TOP = 4'hF;
  localparam int unsigned NUM_PHASES = 6;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned SQUEEZE_CYCLES = 150;

  typedef struct packed {
    logic                checked;
    logic                taint_event;
    logic [NUM_VIOL-1:0] violations;
    logic [31:0]         pointers_down;
  } touch_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  tscc_evt_if touch_evt ();
  tscc_res_if touch_res ();

  touch_stream_consistency_checker_top dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .evt_i   (touch_evt),
    .res_o   (touch_res),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk_i = ~clk_i;

  evt_word_t     pending_events[$];
  touch_result_t expected_results[$];
  evt_word_t     offered_evt;
  int unsigned   mismatches = 0;
  int unsigned   send_idle_pct = 0;
  int unsigned   recv_stall_pct = 0;
  bit            squeeze_on = 1'b0;
  logic          hold_off = 1'b0;

  logic [31:0] class_mask = PCM_RESET;
  logic [31:0] trk_down = '0;
  logic        trk_tainted = 1'b0;
  logic        trk_unhandled = 1'b0;
  logic        trk_dev_valid = 1'b0;
  logic [15:0] trk_dev = '0;
  logic [31:0] trk_src = '0;
  logic        trk_seq_valid = 1'b0;
  logic [31:0] trk_seq = '0;
  logic [1:0]  trk_nest = '0;

  logic [31:0] g_down = '0;
  logic [15:0] g_dev = '0;
  logic [31:0] g_src = 32'd2;
  logic [31:0] seq_ctr = '0;

  function automatic evt_word_t make_evt(input logic [3:0] mode, input logic [31:0] seq,
                                         input logic [1:0] nest, input logic [15:0] dev,
                                         input logic [31:0] src, input logic [5:0] cnt,
                                         input logic [4:0] aidx, input logic [4:0] pid,
                                         input logic [7:0] hist);
    evt_word_t e;
    e.mode          = mode;
    e.seq_number    = seq;
    e.nesting_level = nest;
    e.device_id     = dev;
    e.source_bits   = src;
    e.pointer_count = cnt;
    e.action_index  = aidx;
    e.pointer_id    = pid;
    e.history_size  = hist;
    return e;
  endfunction

  function automatic touch_result_t predict_touch(input evt_word_t e);
    touch_result_t r;
    logic          new_stream;
    logic [31:0]   id_mask;
    r.checked       = 1'b1;
    r.taint_event   = 1'b0;
    r.violations    = '0;
    id_mask = (32'(e.pointer_id) < MAX_POINTER_IDS) ? (32'd1 << e.pointer_id) : '0;
    if (e.mode == MODE_UNHANDLED) begin
      if (e.nesting_level == trk_nest) begin
        trk_unhandled = 1'b1;
      end else begin
        r.checked = 1'b0;
      end
    end else if (trk_seq_valid && e.seq_number == trk_seq && e.nesting_level < trk_nest) begin
      r.checked = 1'b0;
    end else begin
      new_stream = (e.mode == MODE_DOWN) || (e.mode == MODE_CANCEL) ||
                   (e.mode == MODE_OUTSIDE);
      trk_seq_valid = (e.nesting_level != 2'd0);
      trk_seq       = trk_seq_valid ? e.seq_number : '0;
      trk_nest      = e.nesting_level;
      if (new_stream && (trk_tainted || trk_unhandled)) begin
        trk_tainted   = 1'b0;
        trk_unhandled = 1'b0;
        trk_down      = '0;
      end
      r.taint_event = trk_tainted;
      if (!new_stream && trk_dev_valid &&
          (trk_dev != e.device_id || trk_src != e.source_bits)) begin
        r.violations[V_MIXED] = 1'b1;
      end
      trk_dev_valid = 1'b1;
      trk_dev       = e.device_id;
      trk_src       = e.source_bits;
      if ((e.source_bits & class_mask) == '0) begin
        r.violations[V_NOT_PTR] = 1'b1;
      end else begin
        case (e.mode)
          MODE_DOWN: begin
            r.violations[V_DOWN_PTRS] = (trk_down != '0);
            r.violations[V_HISTORY]   = (e.history_size != '0);
            r.violations[V_COUNT_ONE] = (e.pointer_count != 6'd1);
            trk_down = id_mask;
          end
          MODE_UP: begin
            r.violations[V_HISTORY]   = (e.history_size != '0);
            r.violations[V_COUNT_ONE] = (e.pointer_count != 6'd1);
            trk_down    = '0;
            trk_tainted = 1'b0;
          end
          MODE_MOVE: begin
            if (32'(e.pointer_count) != $countones(trk_down)) begin
              r.violations[V_MOVE_CNT] = 1'b1;
              trk_tainted = 1'b1;
            end
          end
          MODE_CANCEL: begin
            trk_down    = '0;
            trk_tainted = 1'b0;
          end
          MODE_OUTSIDE: begin
            r.violations[V_OUTSIDE]   = (trk_down != '0);
            r.violations[V_HISTORY]   = (e.history_size != '0);
            r.violations[V_COUNT_ONE] = (e.pointer_count != 6'd1);
            trk_tainted = 1'b0;
          end
          MODE_POINTER_DOWN: begin
            if (trk_down == '0) begin
              r.violations[V_PD_NONE] = 1'b1;
              trk_tainted = 1'b1;
            end
            if (6'(e.action_index) >= e.pointer_count) begin
              r.violations[V_PD_INDEX] = 1'b1;
              trk_tainted = 1'b1;
            end else if ((trk_down & id_mask) != '0) begin
              r.violations[V_PD_ALREADY] = 1'b1;
              trk_tainted = 1'b1;
            end else begin
              trk_down = trk_down | id_mask;
            end
            r.violations[V_HISTORY] = (e.history_size != '0);
          end
          MODE_POINTER_UP: begin
            if (6'(e.action_index) >= e.pointer_count) begin
              r.violations[V_PU_INDEX] = 1'b1;
              trk_tainted = 1'b1;
            end else if ((trk_down & id_mask) == '0) begin
              r.violations[V_PU_NOTDOWN] = 1'b1;
              trk_tainted = 1'b1;
            end else begin
              trk_down = trk_down & ~id_mask;
            end
            r.violations[V_HISTORY] = (e.history_size != '0);
          end
          default: begin
            r.violations[V_INVALID] = 1'b1;
          end
        endcase
      end
      if (r.violations != '0) begin
        r.taint_event = 1'b1;
      end
    end
    r.pointers_down = trk_down;
    return r;
  endfunction

  function automatic evt_word_t next_touch_event();
    evt_word_t   e;
    int unsigned r;
    int unsigned sub;
    int unsigned live;
    int unsigned off;
    int unsigned k;
    logic        found;
    logic [4:0]  id;
    live  = $countones(g_down);
    r     = $urandom_range(99);
    sub   = $urandom_range(99);
    id    = 5'($urandom());
    found = 1'b0;
    e = make_evt(MODE_MOVE, seq_ctr, 2'd0, g_dev, g_src, 6'(live), 5'd0, 5'd0, 8'd0);
    seq_ctr = seq_ctr + 32'd1;
    if ($urandom_range(99) < 12) begin
      e.nesting_level = 2'($urandom_range(3, 1));
    end
    if ($urandom_range(99) < 10) begin
      e.history_size = 8'($urandom_range(255, 1));
    end
    if (r < 7) begin
      e = make_evt(4'($urandom_range(15)), $urandom(), 2'($urandom()), 16'($urandom()),
                   $urandom(), 6'($urandom_range(32)), 5'($urandom()), 5'($urandom()),
                   8'($urandom()));
    end else if (live == 0 || r < 10) begin
      if ($urandom_range(99) < 30) begin
        g_dev = 16'($urandom());
        g_src = $urandom();
        if ($urandom_range(99) < 90) begin
          g_src = g_src | class_mask;
        end
      end
      e.device_id     = g_dev;
      e.source_bits   = g_src;
      e.pointer_count = ($urandom_range(19) == 0) ? 6'($urandom_range(32)) : 6'd1;
      e.pointer_id    = id;
      if (sub < 85) begin
        e.mode = MODE_DOWN;
        g_down = 32'd1 << id;
      end else if (sub < 93) begin
        e.mode = MODE_OUTSIDE;
        g_down = '0;
      end else begin
        e.mode = MODE_CANCEL;
        g_down = '0;
      end
    end else if (r < 45) begin
      e.history_size = 8'($urandom());
      if (sub < 10) begin
        e.pointer_count = 6'($urandom_range(32));
      end
    end else if (r < 65) begin
      e.mode = MODE_POINTER_DOWN;
      if (g_down[id]) begin
        id = 5'($urandom());
      end
      e.pointer_id    = id;
      e.pointer_count = (live < 32) ? 6'(live + 1) : 6'd32;
      e.action_index  = 5'($urandom_range(32'(e.pointer_count) - 1));
      if (sub < 5) begin
        e.action_index = 5'($urandom());
      end
      g_down[id] = 1'b1;
    end else if (r < 85 && live > 1) begin
      e.mode = MODE_POINTER_UP;
      off = $urandom_range(31);
      for (k = 0; k < 32; k++) begin
        if (!found && g_down[5'(off + k)]) begin
          id    = 5'(off + k);
          found = 1'b1;
        end
      end
      e.pointer_id   = (sub < 5) ? 5'($urandom()) : id;
      e.action_index = 5'($urandom_range(live - 1));
      if (sub > 95) begin
        e.action_index = 5'($urandom());
      end
      g_down[id] = 1'b0;
    end else if (r < 95) begin
      e.mode          = MODE_UP;
      e.pointer_count = 6'd1;
      g_down = '0;
    end else if (r < 97) begin
      e.mode = MODE_CANCEL;
      g_down = '0;
    end else begin
      e.mode = 4'($urandom_range(MODE_UNDEF_TOP, MODE_OTHER));
    end
    return e;
  endfunction

  task automatic write_class_mask(input logic [31:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= CFG_AW'({REG_POINTER_CLASS_MASK, 2'b00});
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    class_mask = value;
  endtask

  task automatic drain_results();
    while (pending_events.size() != 0 || touch_evt.valid || expected_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : drive_p
    if (!rst_ni) begin
      touch_evt.valid <= 1'b0;
    end else begin
      if (touch_evt.valid && touch_evt.ready) begin
        expected_results.push_back(predict_touch(offered_evt));
      end
      if (!touch_evt.valid || touch_evt.ready) begin
        if (pending_events.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          offered_evt = pending_events.pop_front();
          touch_evt.valid         <= 1'b1;
          touch_evt.mode          <= offered_evt.mode;
          touch_evt.seq_number    <= offered_evt.seq_number;
          touch_evt.nesting_level <= offered_evt.nesting_level;
          touch_evt.device_id     <= offered_evt.device_id;
          touch_evt.source_bits   <= offered_evt.source_bits;
          touch_evt.pointer_count <= offered_evt.pointer_count;
          touch_evt.action_index  <= offered_evt.action_index;
          touch_evt.pointer_id    <= offered_evt.pointer_id;
          touch_evt.history_size  <= offered_evt.history_size;
        end else begin
          touch_evt.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : watch_p
    touch_result_t want;
    if (!rst_ni) begin
      touch_res.ready <= 1'b0;
    end else begin
      if (touch_res.valid && touch_res.ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result with none pending: checked %0d taint %0d viol %h ptrs %h",
                   $time, touch_res.checked, touch_res.taint_event, touch_res.violations,
                   touch_res.pointers_down);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (touch_res.checked !== want.checked) begin
            $display("%0t: checked expected %0d got %0d", $time, want.checked,
                     touch_res.checked);
            mismatches++;
          end
          if (touch_res.taint_event !== want.taint_event) begin
            $display("%0t: taint_event expected %0d got %0d", $time, want.taint_event,
                     touch_res.taint_event);
            mismatches++;
          end
          if (touch_res.violations !== want.violations) begin
            $display("%0t: violations expected %h got %h", $time, want.violations,
                     touch_res.violations);
            mismatches++;
          end
          if (touch_res.pointers_down !== want.pointers_down) begin
            $display("%0t: pointers_down expected %h got %h", $time, want.pointers_down,
                     touch_res.pointers_down);
            mismatches++;
          end
        end
      end
      touch_res.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // hold the result side off long enough to back up the input
  initial begin : squeeze_p
    wait (squeeze_on);
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (SQUEEZE_CYCLES) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  initial begin : timeout_p
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus_p
    logic [31:0] phase_mask[NUM_PHASES] = '{32'd2, 32'hFFFF_FFFF, 32'h0, 32'h0,
                                             32'h8000_0000, 32'h0000_0001};
    int unsigned phase_items[NUM_PHASES] = '{300, 300, 60, 400, 250, 340};
    int unsigned phase_send[NUM_PHASES]  = '{0, 47, 0, 34, 0, 34};
    int unsigned phase_recv[NUM_PHASES]  = '{0, 0, 47, 34, 0, 34};
    evt_word_t   e;
    evt_word_t   echo;
    int unsigned p;
    int unsigned n;

    rst_ni                  = 1'b0;
    touch_evt.mode          = '0;
    touch_evt.seq_number    = '0;
    touch_evt.nesting_level = '0;
    touch_evt.device_id     = '0;
    touch_evt.source_bits   = '0;
    touch_evt.pointer_count = '0;
    touch_evt.action_index  = '0;
    touch_evt.pointer_id    = '0;
    touch_evt.history_size  = '0;
    psel                    = 1'b0;
    penable                 = 1'b0;
    pwrite                  = 1'b0;
    paddr                   = '0;
    pwdata                  = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    pending_events.push_back(make_evt(MODE_DOWN, 32'd1, 2'd0, 16'h0, 32'h2, 6'd1, 5'd0, 5'd0, 8'd0));
    pending_events.push_back(make_evt(MODE_POINTER_DOWN, 32'd2, 2'd0, 16'h0, 32'h2, 6'd2,
                                      5'd1, 5'd31, 8'd0));
    pending_events.push_back(make_evt(MODE_MOVE, 32'd3, 2'd0, 16'h0, 32'h2, 6'd2, 5'd0, 5'd0,
                                      8'd255));
    pending_events.push_back(make_evt(MODE_MOVE, 32'd4, 2'd0, 16'h0, 32'h2, 6'd1, 5'd0, 5'd0, 8'd0));
    pending_events.push_back(make_evt(MODE_POINTER_UP, 32'd5, 2'd0, 16'h0, 32'h2, 6'd2, 5'd31,
                                      5'd0, 8'd0));
    pending_events.push_back(make_evt(MODE_DOWN, 32'd6, 2'd0, 16'h0, 32'h2, 6'd0, 5'd0, 5'd5, 8'd1));
    pending_events.push_back(make_evt(MODE_POINTER_DOWN, 32'd7, 2'd0, 16'h0, 32'h2, 6'd2, 5'd0,
                                      5'd5, 8'd0));
    pending_events.push_back(make_evt(MODE_DOWN, 32'd8, 2'd0, 16'h0, 32'h2, 6'd1, 5'd0, 5'd5, 8'd0));
    pending_events.push_back(make_evt(MODE_POINTER_UP, 32'd9, 2'd0, 16'h0, 32'h2, 6'd2, 5'd1,
                                      5'd7, 8'd0));
    pending_events.push_back(make_evt(MODE_CANCEL, 32'd10, 2'd0, 16'h0, 32'h2, 6'd1, 5'd0, 5'd0,
                                      8'd0));
    pending_events.push_back(make_evt(MODE_DOWN, 32'd11, 2'd0, 16'hFFFF, 32'hFFFF_FFFF, 6'd1,
                                      5'd0, 5'd3, 8'd0));
    pending_events.push_back(make_evt(MODE_MOVE, 32'd12, 2'd0, 16'h0, 32'hFFFF_FFFF, 6'd1, 5'd0,
                                      5'd3, 8'd0));
    pending_events.push_back(make_evt(MODE_OTHER, 32'd13, 2'd0, 16'h0, 32'hFFFF_FFFF, 6'd1, 5'd0,
                                      5'd3, 8'd0));
    pending_events.push_back(make_evt(MODE_UNDEF_TOP, 32'd14, 2'd0, 16'h0, 32'hFFFF_FFFF, 6'd1,
                                      5'd0, 5'd3, 8'd0));
    pending_events.push_back(make_evt(MODE_MOVE, 32'd15, 2'd0, 16'h0, 32'hFFFF_FFFD, 6'd1, 5'd0,
                                      5'd3, 8'd0));
    pending_events.push_back(make_evt(MODE_OUTSIDE, 32'd16, 2'd0, 16'h0, 32'h2, 6'd1, 5'd0, 5'd3,
                                      8'd0));
    pending_events.push_back(make_evt(MODE_CANCEL, 32'd17, 2'd0, 16'h0, 32'h2, 6'd1, 5'd0, 5'd0,
                                      8'd0));
    pending_events.push_back(make_evt(MODE_POINTER_DOWN, 32'd18, 2'd0, 16'h0, 32'h2, 6'd1, 5'd0,
                                      5'd2, 8'd0));
    pending_events.push_back(make_evt(MODE_UP, 32'd19, 2'd0, 16'h0, 32'h2, 6'd1, 5'd0, 5'd2, 8'd0));
    pending_events.push_back(make_evt(MODE_DOWN, 32'hFFFF_FFFF, 2'd3, 16'h0, 32'h2, 6'd32, 5'd31,
                                      5'd31, 8'd0));
    pending_events.push_back(make_evt(MODE_MOVE, 32'hFFFF_FFFF, 2'd1, 16'h0, 32'h2, 6'd1, 5'd0,
                                      5'd31, 8'd0));
    pending_events.push_back(make_evt(MODE_UNHANDLED, 32'd20, 2'd3, 16'h0, 32'h2, 6'd1, 5'd0,
                                      5'd0, 8'd0));
    pending_events.push_back(make_evt(MODE_UNHANDLED, 32'd21, 2'd0, 16'h0, 32'h2, 6'd1, 5'd0,
                                      5'd0, 8'd0));
    pending_events.push_back(make_evt(MODE_MOVE, 32'hFFFF_FFFF, 2'd3, 16'h0, 32'h2, 6'd1, 5'd0,
                                      5'd31, 8'd0));
    pending_events.push_back(make_evt(MODE_MOVE, 32'd22, 2'd0, 16'h0, 32'h2, 6'd1, 5'd0, 5'd31,
                                      8'd0));
    pending_events.push_back(make_evt(MODE_DOWN, 32'd23, 2'd0, 16'h0, 32'h2, 6'd1, 5'd0, 5'd0, 8'd0));
    pending_events.push_back(make_evt(MODE_POINTER_DOWN, 32'd24, 2'd0, 16'h0, 32'h2, 6'd0, 5'd0,
                                      5'd4, 8'd0));
    drain_results();

    seq_ctr    = $urandom();
    phase_mask[3] = $urandom();
    for (p = 0; p < NUM_PHASES; p++) begin
      write_class_mask(phase_mask[p]);
      send_idle_pct  = phase_send[p];
      recv_stall_pct = phase_recv[p];
      squeeze_on     = (p == 4);
      for (n = 0; n < phase_items[p]; n++) begin
        e = next_touch_event();
        pending_events.push_back(e);
        // replay some nested words at a shallower level
        if (e.nesting_level != 2'd0 && $urandom_range(1) == 1) begin
          echo = e;
          echo.nesting_level = 2'($urandom_range(32'(e.nesting_level) - 1));
          if ($urandom_range(3) == 0) begin
            echo.mode = 4'($urandom_range(15));
          end
          pending_events.push_back(echo);
        end
        if ($urandom_range(99) < 3) begin
          pending_events.push_back(make_evt(MODE_UNHANDLED, $urandom(),
                                            ($urandom_range(1) == 1) ? e.nesting_level
                                                                      : 2'($urandom()),
                                            16'($urandom()), $urandom(),
                                            6'($urandom_range(32)), 5'($urandom()),
                                            5'($urandom()), 8'($urandom())));
        end
      end
      drain_results();
    end

    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
